>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MEXP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and control types of the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DEF_WIDTH = 32;   // datapath width
  localparam int FIELD_W   = 32;   // width of message, result and registers
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_SEL_BIT = 2;  // word select within paddr

  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  localparam logic [FIELD_W-1:0] MODULUS_RST  = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] EXPONENT_RST = '0;

  // Command to the bit-serial multiply unit
  typedef struct packed {
    logic start;
    logic reduce;   // reduce the multiplier operand instead of multiplying
  } mul_ctrl_t;

  // Status from the bit-serial multiply unit
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

>>> sv/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels for messages in and results out.
// ----------------------------------------------------------------------------
interface mexp_msg_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::FIELD_W-1:0]   message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface mexp_res_if;
  logic                           valid;
  logic                           ready;
  logic [mexp_pkg::FIELD_W-1:0]   power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

>>> sv/mexp_mul.sv
// ----------------------------------------------------------------------------
// mexp_mul
// Bit-serial modular double-and-add unit with two accumulators that share
// one multiplier shift register. Each multiplier bit takes a double step, then an add step.
// ----------------------------------------------------------------------------
module mexp_mul #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::mul_ctrl_t ctrl,
  input  logic [WIDTH-1:0]    modulus,
  input  logic [WIDTH-1:0]    x_a,
  input  logic [WIDTH-1:0]    x_b,
  input  logic [WIDTH-1:0]    y,
  output mexp_pkg::mul_stat_t stat,
  output logic [WIDTH-1:0]    acc_a,
  output logic [WIDTH-1:0]    acc_b
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_a_r;
  logic [WIDTH-1:0] acc_b_r;
  logic [WIDTH-1:0] y_sh;
  logic [CW-1:0]    cnt;
  logic             phase;
  logic             busy;
  logic             done;
  logic             reduce_r;

  logic             ybit;
  logic [WIDTH:0]   sum_a;
  logic [WIDTH:0]   sum_b;
  logic [WIDTH-1:0] red_a;
  logic [WIDTH-1:0] red_b;

  // one conditional subtract; a zero modulus wraps at WIDTH bits
  function automatic logic [WIDTH-1:0] fold(input logic [WIDTH:0] s,
                                            input logic [WIDTH-1:0] m);
    logic [WIDTH:0] d;
    d = s - {1'b0, m};
    if ((m != '0) && (s >= {1'b0, m})) fold = d[WIDTH-1:0];
    else fold = s[WIDTH-1:0];
  endfunction

  assign ybit = y_sh[WIDTH-1];

  always_comb begin
    if (!phase) begin
      sum_a = {acc_a_r, 1'b0};
      sum_b = {acc_b_r, reduce_r & ybit};
    end else begin
      sum_a = {1'b0, acc_a_r} + {1'b0, x_a};
      sum_b = {1'b0, acc_b_r} + {1'b0, x_b};
    end
    red_a = fold(sum_a, modulus);
    red_b = fold(sum_b, modulus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (ctrl.start) begin
          busy  <= 1'b1;
          phase <= 1'b0;
        end
      end else if (!phase) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      if (ctrl.start) begin
        acc_a_r  <= '0;
        acc_b_r  <= '0;
        y_sh     <= y;
        cnt      <= CW'(WIDTH - 1);
        reduce_r <= ctrl.reduce;
      end
    end else if (!phase) begin
      acc_a_r <= red_a;
      acc_b_r <= red_b;
    end else begin
      if (!reduce_r && ybit) begin
        acc_a_r <= red_a;
        acc_b_r <= red_b;
      end
      y_sh <= {y_sh[WIDTH-2:0], 1'b0};
      cnt  <= cnt - CW'(1);
    end
  end

  assign stat  = '{busy: busy, done: done};
  assign acc_a = acc_a_r;
  assign acc_b = acc_b_r;

endmodule

>>> sv/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Steps: reduce the base mod the modulus, then one multiply-and-square pass per
//   exponent bit up to its highest set bit (none for a zero exponent). Each
//   modular multiply walks the multiplier one bit at a time.
// Throughput: one item at a time; the next item is taken once the last is
//   parked in the output register. Reset: synchronous, modulus 1, exponent 0.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mexp_pkg::APB_AW-1:0]   paddr,
  input  logic [mexp_pkg::APB_DW-1:0]   pwdata,
  output logic [mexp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  mexp_msg_if.sink                      msg,
  mexp_res_if.source                    res
);

  localparam int FW = mexp_pkg::FIELD_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;  // wait for a message
  localparam logic [1:0] ST_REDUCE = 2'd1;  // base mod modulus
  localparam logic [1:0] ST_MUL    = 2'd2;  // one exponent bit: multiply and square
  localparam logic [1:0] ST_DONE   = 2'd3;  // park result in the output register

  logic [FW-1:0]     modulus_reg;
  logic [FW-1:0]     exponent_reg;
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [WIDTH-1:0]  e_sh;
  logic [WIDTH-1:0]  result;
  logic [WIDTH-1:0]  base;
  logic              out_valid;
  logic [FW-1:0]     out_data;

  logic [WIDTH-1:0]  m_w;
  logic [WIDTH-1:0]  e_w;
  logic [WIDTH-1:0]  e_next;
  logic              in_acc;
  logic              out_load;
  logic              cfg_wr;
  logic [WIDTH-1:0]  y_in;
  logic [WIDTH-1:0]  acc_a;
  logic [WIDTH-1:0]  acc_b;

  mexp_pkg::mul_ctrl_t mul_ctrl;
  mexp_pkg::mul_stat_t mul_stat;

  assign m_w    = WIDTH'(modulus_reg);
  assign e_w    = WIDTH'(exponent_reg);
  assign e_next = {1'b0, e_sh[WIDTH-1:1]};

  // --------------------------------------------------------------------------
  // Configuration port: word select on one address bit, always ready
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[mexp_pkg::REG_SEL_BIT] == mexp_pkg::REG_EXPONENT)
                  ? mexp_pkg::APB_DW'(exponent_reg)
                  : mexp_pkg::APB_DW'(modulus_reg);

  // --------------------------------------------------------------------------
  // Handshakes: take a message only when idle; the output register frees
  // the sequencer while a result waits to be taken
  // --------------------------------------------------------------------------
  assign msg.ready        = (state == ST_IDLE);
  assign in_acc           = msg.valid && msg.ready;
  assign out_load         = (state == ST_DONE) && (!out_valid || res.ready);
  assign res.valid        = out_valid;
  assign res.power_result = out_data;

  // --------------------------------------------------------------------------
  // Sequencer. Multiply and square share the base as multiplier, so both run
  // together in the serial unit: acc_a is result*base, acc_b is base*base.
  // A restart takes the fresh base straight from the unit's accumulator.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_ctrl   = '0;
    y_in       = acc_b;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          mul_ctrl.start  = 1'b1;
          mul_ctrl.reduce = 1'b1;
          y_in            = WIDTH'(msg.message);
          state_next      = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          if (e_sh == '0) begin
            state_next = ST_DONE;
          end else begin
            mul_ctrl.start = 1'b1;
            state_next     = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          if (e_next == '0) begin
            state_next = ST_DONE;
          end else begin
            mul_ctrl.start = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      modulus_reg  <= mexp_pkg::MODULUS_RST;
      exponent_reg <= mexp_pkg::EXPONENT_RST;
    end else begin
      state <= state_next;
      // hold a waiting result until taken, load a fresh one when free
      out_valid <= out_load || (out_valid && !res.ready);
      if (cfg_wr) begin
        if (paddr[mexp_pkg::REG_SEL_BIT] == mexp_pkg::REG_MODULUS) begin
          modulus_reg <= FW'(pwdata);
        end else begin
          exponent_reg <= FW'(pwdata);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_sh <= e_w;
      // start at 1 mod modulus; a zero exponent always gives 1
      if ((e_w != '0) && (m_w == WIDTH'(1))) result <= '0;
      else result <= WIDTH'(1);
    end
    if ((state == ST_REDUCE) && mul_stat.done) begin
      base <= acc_b;
    end
    if ((state == ST_MUL) && mul_stat.done) begin
      if (e_sh[0]) result <= acc_a;
      base <= acc_b;
      e_sh <= e_next;
    end
    if (out_load) out_data <= FW'(result);
  end

  // --------------------------------------------------------------------------
  // Serial modular multiply / reduce unit
  // --------------------------------------------------------------------------
  mexp_mul #(
    .WIDTH (WIDTH)
  ) u_mexp_mul (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mul_ctrl),
    .modulus (m_w),
    .x_a     (result),
    .x_b     (base),
    .y       (y_in),
    .stat    (mul_stat),
    .acc_a   (acc_a),
    .acc_b   (acc_b)
  );

endmodule

>>> sv/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mexp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mexp_pkg::FIELD_W-1:0]  out_data
);

  // a waiting result holds until taken
  `MEXP_ASSERT_NEXT(a_res_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // one item in flight: the input closes right after an accept
  `MEXP_ASSERT_NEXT(a_single_item, clk, rst, in_valid && in_ready, !in_ready)

  // no result appears in the cycle after an accept
  `MEXP_ASSERT_NEXT(a_no_early_res, clk, rst, in_valid && in_ready, !$rose(out_valid))

  // leaving reset: idle and empty
  `MEXP_ASSERT_IMPL(a_reset_idle, clk, rst, $past(rst), !out_valid && in_ready)

  // the register port never stalls
  `MEXP_ASSERT_IMPL(a_apb_ready, clk, rst, psel, pready)

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .pready    (pready),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_data  (res.power_result)
);
